/* src/pa_pkg.sv */
package pa_pkg;

  // Widths of the fields on the ports.
  localparam int VID_W = 16;
  localparam int CNT_W = 16;

  // Internal widths of the stored vertex handles and of the batch count.
  localparam int VID_BITS = 16;
  localparam int CNT_BITS = 16;

  // Width used for limit compares, wide enough for any count plus two.
  localparam int CMP_W = 34;

  // Configuration register index width.
  localparam int CFG_IDX_BITS = 2;

  // Result queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_BITS = 2;

  typedef enum logic [2:0] {
    MODE_POINTS     = 3'd0,
    MODE_LINES      = 3'd1,
    MODE_LINE_STRIP = 3'd2,
    MODE_LINE_LOOP  = 3'd3,
    MODE_TRIS       = 3'd4,
    MODE_TRI_STRIP  = 3'd5,
    MODE_TRI_FAN    = 3'd6,
    MODE_QUADS      = 3'd7
  } draw_mode_t;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_TRI   = 2'd2
  } prim_kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DRAW_MODE  = 2'd0,
    REG_PRIM_LIMIT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic             prim_valid;
    prim_kind_t       prim_kind;
    logic [VID_W-1:0] vert_a;
    logic [VID_W-1:0] vert_b;
    logic [VID_W-1:0] vert_c;
    logic             batch_done;
    logic [CNT_W-1:0] total_prims;
  } result_t;

  // Up to two results produced by one vertex beat.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } result_pair_t;

endpackage

/* src/pa_if.sv */
interface pa_vtx_if;
  logic                    valid;
  logic                    ready;
  logic [pa_pkg::VID_W-1:0] vertex_id;
  logic                    last_vertex;

  modport source (output valid, output vertex_id, output last_vertex, input ready);
  modport sink (input valid, input vertex_id, input last_vertex, output ready);
endinterface

interface pa_prim_if;
  logic                    valid;
  logic                    ready;
  logic                    prim_valid;
  logic [1:0]              prim_kind;
  logic [pa_pkg::VID_W-1:0] vert_a;
  logic [pa_pkg::VID_W-1:0] vert_b;
  logic [pa_pkg::VID_W-1:0] vert_c;
  logic                    batch_done;
  logic [pa_pkg::CNT_W-1:0] total_prims;

  modport source (output valid, output prim_valid, output prim_kind, output vert_a,
                  output vert_b, output vert_c, output batch_done, output total_prims,
                  input ready);
  modport sink (input valid, input prim_valid, input prim_kind, input vert_a,
                input vert_b, input vert_c, input batch_done, input total_prims,
                output ready);
endinterface

interface pa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pa_pkg::CFG_IDX_BITS-1:0] index;
  logic [15:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/pa_asm.sv */
module pa_asm (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [pa_pkg::VID_W-1:0]     vertex_id,
  input  logic                         last_vertex,
  input  pa_pkg::draw_mode_t           draw_mode,
  input  logic [15:0]                  prim_limit,
  output pa_pkg::result_pair_t         results
);

  localparam logic [pa_pkg::CMP_W-1:0] CAP =
    pa_pkg::CMP_W'((64'd1 << pa_pkg::CNT_BITS) - 64'd1);

  // Batch state.
  logic [3:0]                    pos;
  logic [pa_pkg::VID_BITS-1:0]   h0, h1, h2, first;
  logic [pa_pkg::CNT_BITS-1:0]   count;

  logic [pa_pkg::VID_BITS-1:0]   v, first_eff;
  logic [pa_pkg::CMP_W-1:0]      lim, cnt0, cnt1;
  logic                          want1, want2, e1, e2, quad_room;
  pa_pkg::prim_kind_t            kind;
  logic [pa_pkg::VID_BITS-1:0]   a1, b1, c1, a2, b2, c2;
  logic                          pos_mod3_is2;

  assign v         = pa_pkg::VID_BITS'(vertex_id);
  assign first_eff = (pos == 4'd0) ? v : first;

  // Effective limit is the configured one, capped by the counter range.
  assign lim  = (pa_pkg::CMP_W'(prim_limit) < CAP) ? pa_pkg::CMP_W'(prim_limit) : CAP;
  assign cnt0 = pa_pkg::CMP_W'(count);
  assign quad_room = (cnt0 + pa_pkg::CMP_W'(2)) <= lim;

  // The position wraps from 14 to 3, so its residue mod 3 is a short list.
  assign pos_mod3_is2 = (pos == 4'd2) || (pos == 4'd5) || (pos == 4'd8) ||
                        (pos == 4'd11) || (pos == 4'd14);

  // Primitive selection for the current draw mode.
  always_comb begin
    want1 = 1'b0;
    want2 = 1'b0;
    kind  = pa_pkg::KIND_POINT;
    a1 = '0; b1 = '0; c1 = '0;
    a2 = '0; b2 = '0; c2 = '0;
    unique case (draw_mode)
      pa_pkg::MODE_POINTS: begin
        want1 = 1'b1;
        a1    = v;
      end
      pa_pkg::MODE_LINES: begin
        kind  = pa_pkg::KIND_LINE;
        want1 = pos[0];
        a1    = h0;
        b1    = v;
      end
      pa_pkg::MODE_LINE_STRIP, pa_pkg::MODE_LINE_LOOP: begin
        kind  = pa_pkg::KIND_LINE;
        want1 = (pos != 4'd0);
        a1    = h0;
        b1    = v;
        // Closing line of a loop follows the strip line of the last vertex.
        want2 = (draw_mode == pa_pkg::MODE_LINE_LOOP) && last_vertex && (pos >= 4'd2);
        a2    = v;
        b2    = first_eff;
      end
      pa_pkg::MODE_TRIS: begin
        kind  = pa_pkg::KIND_TRI;
        want1 = pos_mod3_is2;
        a1    = h1;
        b1    = h0;
        c1    = v;
      end
      pa_pkg::MODE_TRI_STRIP: begin
        kind  = pa_pkg::KIND_TRI;
        want1 = (pos >= 4'd2);
        a1    = pos[0] ? h0 : h1;
        b1    = pos[0] ? h1 : h0;
        c1    = v;
      end
      pa_pkg::MODE_TRI_FAN: begin
        kind  = pa_pkg::KIND_TRI;
        want1 = (pos >= 4'd2);
        a1    = first_eff;
        b1    = h0;
        c1    = v;
      end
      pa_pkg::MODE_QUADS: begin
        kind  = pa_pkg::KIND_TRI;
        want1 = (pos[1:0] == 2'd3) && quad_room;
        want2 = want1;
        a1    = h2;
        b1    = h1;
        c1    = h0;
        a2    = h2;
        b2    = h0;
        c2    = v;
      end
      default: begin
        want1 = 1'b0;
      end
    endcase
  end

  // Limit checks, the second one sees the count after the first.
  assign e1   = want1 && (cnt0 < lim);
  assign cnt1 = cnt0 + pa_pkg::CMP_W'(e1);
  assign e2   = want2 && (cnt1 < lim);

  // Result assembly, with the done flag on the last result of the last vertex.
  always_comb begin
    results = '0;
    results.r0.prim_valid  = 1'b1;
    results.r0.prim_kind   = kind;
    results.r0.vert_a      = pa_pkg::VID_W'(a1);
    results.r0.vert_b      = pa_pkg::VID_W'(b1);
    results.r0.vert_c      = pa_pkg::VID_W'(c1);
    results.r0.total_prims = pa_pkg::CNT_W'(cnt1);
    results.r1.prim_valid  = 1'b1;
    results.r1.prim_kind   = kind;
    results.r1.vert_a      = pa_pkg::VID_W'(a2);
    results.r1.vert_b      = pa_pkg::VID_W'(b2);
    results.r1.vert_c      = pa_pkg::VID_W'(c2);
    results.r1.total_prims = pa_pkg::CNT_W'(cnt1 + pa_pkg::CMP_W'(1));
    if (!accept) begin
      results.count = 2'd0;
    end else if (e1 && e2) begin
      results.count         = 2'd2;
      results.r1.batch_done = last_vertex;
    end else if (e1) begin
      results.count         = 2'd1;
      results.r0.batch_done = last_vertex;
    end else if (last_vertex) begin
      results.count          = 2'd1;
      results.r0             = '0;
      results.r0.batch_done  = 1'b1;
      results.r0.total_prims = pa_pkg::CNT_W'(cnt0);
    end else begin
      results.count = 2'd0;
    end
  end

  // Batch state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      count <= '0;
      h0    <= '0;
      h1    <= '0;
      h2    <= '0;
      first <= '0;
    end else if (accept) begin
      h2    <= h1;
      h1    <= h0;
      h0    <= v;
      first <= first_eff;
      if (last_vertex) begin
        pos   <= '0;
        count <= '0;
      end else begin
        pos   <= (pos >= 4'd14) ? 4'd3 : pos + 4'd1;
        count <= pa_pkg::CNT_BITS'(cnt1 + pa_pkg::CMP_W'(e2));
      end
    end
  end

endmodule

/* src/pa_outq.sv */
module pa_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  pa_pkg::result_pair_t push,
  input  logic                 pop,
  output logic                 not_empty,
  output logic                 room,
  output pa_pkg::result_t      head
);

  pa_pkg::result_t                 entries [pa_pkg::Q_DEPTH];
  logic [pa_pkg::Q_PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [pa_pkg::Q_PTR_BITS:0]     fill, fill_next;

  assign not_empty = (fill != '0);
  assign room      = (fill <= (pa_pkg::Q_PTR_BITS + 1)'(pa_pkg::Q_DEPTH - 2));
  assign head      = entries[rd_ptr];

  assign fill_next = fill + (pa_pkg::Q_PTR_BITS + 1)'(push.count)
                   - (pa_pkg::Q_PTR_BITS + 1)'(pop);

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + pa_pkg::Q_PTR_BITS'(push.count);
      rd_ptr <= rd_ptr + pa_pkg::Q_PTR_BITS'(pop);
      fill   <= fill_next;
    end
  end

  // Result storage, up to two entries written per beat.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + pa_pkg::Q_PTR_BITS'(1)] <= push.r1;
    end
  end

endmodule

/* src/primitive_assembler_core.sv */
// Primitive assembler. Vertex handles arrive one beat at a time on vtx, with
// last_vertex set on the final vertex of a batch; assembled points, lines and
// triangles leave on prim under the draw mode and per-batch primitive limit
// held in two registers written through cfg (index 0 draw_mode, index 1
// prim_limit; other indexes are ignored). Each vertex is assembled in the
// cycle it is accepted and its results are written into a four-entry result
// queue, so a vertex beat can be taken every cycle while the queue has room
// for two results. A vertex yields at most two results (quads and the closing
// line of a loop), and the queue drains one result per cycle while prim is
// ready, so modes with two results per vertex run at the output rate. The
// batch's last vertex always ends on a result carrying batch_done and total.
// Users write configuration only while no vertex is in flight; not enforced.
module primitive_assembler_core (
  input logic       clk,
  input logic       rst,
  pa_vtx_if.sink    vtx,
  pa_prim_if.source prim,
  pa_cfg_if.sink    cfg
);

  pa_pkg::draw_mode_t   draw_mode;
  logic [15:0]          prim_limit;
  logic                 accept;
  logic                 room;
  pa_pkg::result_pair_t results;
  pa_pkg::result_t      head;

  assign cfg.ready = 1'b1;
  assign vtx.ready = room;
  assign accept    = vtx.valid && vtx.ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_mode  <= pa_pkg::MODE_POINTS;
      prim_limit <= 16'hFFFF;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pa_pkg::REG_DRAW_MODE:  draw_mode  <= pa_pkg::draw_mode_t'(cfg.data[2:0]);
        pa_pkg::REG_PRIM_LIMIT: prim_limit <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  pa_asm u_asm (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .vertex_id   (vtx.vertex_id),
    .last_vertex (vtx.last_vertex),
    .draw_mode   (draw_mode),
    .prim_limit  (prim_limit),
    .results     (results)
  );

  pa_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (results),
    .pop       (prim.valid && prim.ready),
    .not_empty (prim.valid),
    .room      (room),
    .head      (head)
  );

  // Result beat fields.
  assign prim.prim_valid  = head.prim_valid;
  assign prim.prim_kind   = head.prim_kind;
  assign prim.vert_a      = head.vert_a;
  assign prim.vert_b      = head.vert_b;
  assign prim.vert_c      = head.vert_c;
  assign prim.batch_done  = head.batch_done;
  assign prim.total_prims = head.total_prims;

endmodule

/* src/pa_checker.sv */
module pa_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic        prim_valid,
  input logic [1:0]  prim_kind,
  input logic [15:0] vert_a,
  input logic [15:0] vert_b,
  input logic [15:0] vert_c,
  input logic        batch_done,
  input logic [15:0] total_prims
);

  // A stalled result beat holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable({prim_valid, prim_kind, vert_a, vert_b, vert_c,
                                          batch_done, total_prims}))
    else $error("result beat changed while stalled");

  // A result without a primitive only ever closes a batch.
  assert property (@(posedge clk) disable iff (rst)
    valid && !prim_valid |-> batch_done)
    else $error("marker result without batch_done");

  // A done marker carries no vertices.
  assert property (@(posedge clk) disable iff (rst)
    valid && !prim_valid |-> prim_kind == 2'd0 && vert_a == 16'd0 && vert_b == 16'd0 &&
                             vert_c == 16'd0)
    else $error("marker result carries vertex data");

  // An emitted primitive is counted, so its total is never zero.
  assert property (@(posedge clk) disable iff (rst)
    valid && prim_valid |-> total_prims != 16'd0)
    else $error("primitive with zero total");

endmodule

bind primitive_assembler_core pa_checker u_pa_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (prim.valid),
  .ready       (prim.ready),
  .prim_valid  (prim.prim_valid),
  .prim_kind   (prim.prim_kind),
  .vert_a      (prim.vert_a),
  .vert_b      (prim.vert_b),
  .vert_c      (prim.vert_c),
  .batch_done  (prim.batch_done),
  .total_prims (prim.total_prims)
);

/* dv/tb_primitive_assembler_core.sv */
`timescale 1ns / 1ps

module tb_primitive_assembler_core;
  import pa_pkg::*;

  localparam int COUNT_CAP = (1 << CNT_BITS) - 1;
  localparam int RANDOM_VERTICES_PER_PHASE = 190;

  // Indexes past the register list; writes to them must be ignored.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

  logic clk;
  logic rst;

  pa_vtx_if  vtx_bus ();
  pa_prim_if prim_bus ();
  pa_cfg_if  cfg_bus ();

  primitive_assembler_core u_top (
    .clk  (clk),
    .rst  (rst),
    .vtx  (vtx_bus),
    .prim (prim_bus),
    .cfg  (cfg_bus)
  );

  // Predictor state: registers as written, and the batch being assembled.
  draw_mode_t       cur_mode = MODE_POINTS;
  logic [15:0]      cur_limit = 16'hFFFF;
  int               vpos = 0;
  logic [VID_W-1:0] held [3] = '{default: '0};
  logic [VID_W-1:0] first_vid = '0;
  int               batch_count = 0;

  result_t pending_prims [$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int vertices_sent = 0;
  int batches_closed = 0;
  int prims_checked = 0;
  int errors = 0;

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    prim_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Queue one primitive if the batch still has room under the limit.
  function automatic void emit_prim(prim_kind_t kind, logic [VID_W-1:0] a,
                                    logic [VID_W-1:0] b, logic [VID_W-1:0] c);
    result_t r;
    if (batch_count >= int'(cur_limit) || batch_count >= COUNT_CAP) begin
      return;
    end
    batch_count++;
    r = '0;
    r.prim_valid = 1'b1;
    r.prim_kind = kind;
    r.vert_a = a;
    r.vert_b = b;
    r.vert_c = c;
    r.total_prims = batch_count[CNT_W-1:0];
    pending_prims.push_back(r);
  endfunction

  // A quad goes out only if both of its triangles fit.
  function automatic bit quad_fits();
    int lim;
    lim = (COUNT_CAP < int'(cur_limit)) ? COUNT_CAP : int'(cur_limit);
    return (batch_count <= lim) && (lim - batch_count >= 2);
  endfunction

  // Work out the primitives that one accepted vertex produces.
  function automatic void assemble_vertex(logic [VID_W-1:0] vid, logic last);
    int p;
    int queued_before;
    logic [VID_W-1:0] h0, h1, h2;
    result_t r;
    p = vpos;
    h0 = held[0];
    h1 = held[1];
    h2 = held[2];
    queued_before = pending_prims.size();
    if (p == 0) begin
      first_vid = vid;
    end
    case (cur_mode)
      MODE_POINTS: begin
        emit_prim(KIND_POINT, vid, '0, '0);
      end
      MODE_LINES: begin
        if (p % 2 == 1) emit_prim(KIND_LINE, h0, vid, '0);
      end
      MODE_LINE_STRIP, MODE_LINE_LOOP: begin
        if (p >= 1) emit_prim(KIND_LINE, h0, vid, '0);
        // The loop closes back to the first vertex after the strip line.
        if (cur_mode == MODE_LINE_LOOP && last && p >= 2) begin
          emit_prim(KIND_LINE, vid, first_vid, '0);
        end
      end
      MODE_TRIS: begin
        if (p % 3 == 2) emit_prim(KIND_TRI, h1, h0, vid);
      end
      MODE_TRI_STRIP: begin
        // Odd triangles swap their first two vertices to keep the winding.
        if (p >= 2) begin
          if (p % 2 == 0) emit_prim(KIND_TRI, h1, h0, vid);
          else emit_prim(KIND_TRI, h0, h1, vid);
        end
      end
      MODE_TRI_FAN: begin
        if (p >= 2) emit_prim(KIND_TRI, first_vid, h0, vid);
      end
      default: begin
        if (p % 4 == 3 && quad_fits()) begin
          emit_prim(KIND_TRI, h2, h1, h0);
          emit_prim(KIND_TRI, h2, h0, vid);
        end
      end
    endcase
    held[2] = h1;
    held[1] = h0;
    held[0] = vid;
    vpos = (p >= 14) ? 3 : p + 1;
    // The last vertex ends on a done beat, a bare marker if nothing was emitted.
    if (last) begin
      if (pending_prims.size() == queued_before) begin
        r = '0;
        r.batch_done = 1'b1;
        r.total_prims = batch_count[CNT_W-1:0];
        pending_prims.push_back(r);
      end else begin
        r = pending_prims.pop_back();
        r.batch_done = 1'b1;
        pending_prims.push_back(r);
      end
      vpos = 0;
      batch_count = 0;
      batches_closed++;
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Compare every accepted primitive beat with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && prim_bus.valid && prim_bus.ready) begin
      if (pending_prims.size() == 0) begin
        $error("unexpected primitive beat: vert_a 0x%0h total_prims %0d",
               prim_bus.vert_a, prim_bus.total_prims);
        errors++;
      end else begin
        want = pending_prims.pop_front();
        check_field("prim_valid", 16'(want.prim_valid), 16'(prim_bus.prim_valid));
        check_field("prim_kind", 16'(want.prim_kind), 16'(prim_bus.prim_kind));
        check_field("vert_a", want.vert_a, prim_bus.vert_a);
        check_field("vert_b", want.vert_b, prim_bus.vert_b);
        check_field("vert_c", want.vert_c, prim_bus.vert_c);
        check_field("batch_done", 16'(want.batch_done), 16'(prim_bus.batch_done));
        check_field("total_prims", want.total_prims, prim_bus.total_prims);
        prims_checked++;
      end
    end
  end

  // Drive one vertex beat, with random idle cycles ahead of it.
  task automatic send_vertex(input logic [VID_W-1:0] vid, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      vtx_bus.valid <= 1'b0;
      @(negedge clk);
    end
    vtx_bus.valid <= 1'b1;
    vtx_bus.vertex_id <= vid;
    vtx_bus.last_vertex <= last;
    do @(posedge clk); while (!vtx_bus.ready);
    assemble_vertex(vid, last);
    vertices_sent++;
  endtask

  // Stop sending and wait until every expected primitive has come out.
  task automatic wait_quiet();
    @(negedge clk);
    vtx_bus.valid <= 1'b0;
    while (pending_prims.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] data);
    wait_quiet();
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == REG_DRAW_MODE) cur_mode = draw_mode_t'(data[2:0]);
    else if (idx == REG_PRIM_LIMIT) cur_limit = data;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [VID_W-1:0] pick_vid();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return VID_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_batch(input int len, input bit close);
    for (int i = 0; i < len; i++) begin
      send_vertex(pick_vid(), close && (i == len - 1));
    end
  endtask

  // Reset registers: points with the full limit, lowest and highest handles.
  task automatic check_reset_defaults();
    send_vertex(16'h0000, 1'b0);
    send_vertex(16'hFFFF, 1'b1);
  endtask

  // One short batch per draw mode, long enough for its first primitive.
  task automatic check_each_mode();
    int n;
    logic [VID_W-1:0] vid;
    for (int m = 0; m < 8; m++) begin
      write_reg(REG_DRAW_MODE, 16'(m));
      case (draw_mode_t'(m))
        MODE_POINTS, MODE_LINES, MODE_LINE_STRIP: n = 2;
        MODE_TRI_STRIP, MODE_QUADS: n = 4;
        default: n = 3;
      endcase
      for (int i = 0; i < n; i++) begin
        vid = (i == 0) ? ((m % 2 == 1) ? 16'hFFFF : 16'h0000) : 16'(m * 16'h0100 + i);
        send_vertex(vid, i == n - 1);
      end
    end
  endtask

  // A last vertex with nothing to emit, and a loop too short to close.
  task automatic check_batch_edges();
    write_reg(REG_DRAW_MODE, 16'(MODE_LINES));
    send_vertex(16'h1234, 1'b1);
    write_reg(REG_DRAW_MODE, 16'(MODE_LINE_LOOP));
    send_vertex(16'hA5A5, 1'b0);
    send_vertex(16'h5A5A, 1'b1);
  endtask

  // Zero limit, a quad without room for both halves, a loop losing its close.
  task automatic check_limits();
    write_reg(REG_PRIM_LIMIT, 16'd0);
    write_reg(REG_DRAW_MODE, 16'(MODE_POINTS));
    send_vertex(16'h0042, 1'b1);
    write_reg(REG_PRIM_LIMIT, 16'd1);
    write_reg(REG_DRAW_MODE, 16'(MODE_QUADS));
    for (int i = 0; i < 4; i++) send_vertex(16'(16'h0700 + i), i == 3);
    write_reg(REG_PRIM_LIMIT, 16'd2);
    write_reg(REG_DRAW_MODE, 16'(MODE_LINE_LOOP));
    for (int i = 0; i < 3; i++) send_vertex(16'(16'h0300 + i), i == 2);
    write_reg(REG_PRIM_LIMIT, 16'hFFFF);
  endtask

  // Mode changed with a batch half done, plus writes to unused indexes.
  task automatic check_mid_batch_switch();
    write_reg(REG_DRAW_MODE, 16'(MODE_TRI_FAN));
    send_vertex(16'h0011, 1'b0);
    send_vertex(16'h0022, 1'b0);
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'(VID_W'($urandom_range(0, 65535))));
    write_reg(REG_DRAW_MODE, 16'(MODE_LINE_STRIP));
    send_vertex(16'h0033, 1'b1);
  endtask

  // Random modes, limits and batch lengths under one mix of idling.
  task automatic random_phase(input int src_pct, input int sink_pct);
    int start;
    int len;
    logic [15:0] lim;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    start = vertices_sent;
    while (vertices_sent - start < RANDOM_VERTICES_PER_PHASE) begin
      write_reg(REG_DRAW_MODE, 16'($urandom_range(0, 7)));
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0: lim = 16'd0;
          1, 2: lim = 16'($urandom_range(1, 6));
          3: lim = 16'($urandom_range(0, 65535));
          default: lim = 16'hFFFF;
        endcase
        write_reg(REG_PRIM_LIMIT, lim);
      end
      if ($urandom_range(0, 15) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  16'($urandom_range(0, 65535)));
      end
      repeat ($urandom_range(1, 4)) begin
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        // Now and then a batch is left open so the next setting applies mid-batch.
        send_batch(len, $urandom_range(0, 9) != 0);
      end
    end
  endtask

  task automatic run_random_traffic();
    random_phase(0, 0);
    random_phase(53, 0);
    random_phase(0, 53);
    random_phase(6, 6);
    random_phase(0, 0);
    // Close whatever batch the last phase left open.
    send_vertex(pick_vid(), 1'b1);
  endtask

  // Run deadline well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    vtx_bus.valid = 1'b0;
    vtx_bus.vertex_id = '0;
    vtx_bus.last_vertex = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_reset_defaults();
    check_each_mode();
    check_batch_edges();
    check_limits();
    check_mid_batch_switch();
    run_random_traffic();

    wait_quiet();
    repeat (8) @(posedge clk);
    $display("Sent %0d vertices in %0d closed batches over all draw modes and limits.",
             vertices_sent, batches_closed);
    $display("Checked %0d primitive beats under five idle mixes; %0d errors.",
             prims_checked, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
